>>> sv/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

`define ASSERT_NOW(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

>>> sv/sha2_pkg.sv
package sha2_pkg;

    localparam int LenBitsDefault = 61;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } sha2_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } sha2_out_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PAD,
        ST_LOADW,
        ST_ROUND,
        ST_FOLD,
        ST_OUTRD,
        ST_OUT
    } sha2_state_t;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] init_value(input logic sel224, input logic [2:0] i);
        logic [31:0] a [8];
        logic [31:0] b [8];
        a = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        b = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
              32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
        return sel224 ? b[i] : a[i];
    endfunction

endpackage

>>> sv/sha256_sha224_hash_engine_core.sv
// SHA-256 / SHA-224 byte-stream hasher. At most one message byte per item; an idle core
// accepts an item every cycle. When a byte completes a 64-byte block the input
// stalls while the block streams out of the byte buffer memory into the message
// schedule and the chain value is read into the working registers, then for the
// 64 rounds, and while the working registers are added back into the chain
// memory. An item with is_last pads one byte per cycle to the end of the block.
// A second padding block follows when fewer than 8 bytes were free after the
// 0x80 byte. Each padded block goes through the same steps. The 8 or 7 digest
// words then leave one at a time, each read from the chain memory first, while
// out_stall is low. After reset, after a mode write and after each digest, the
// initial value is reloaded into the chain memory. in_stall is high while the
// core is not idle or a mode write is waiting.
module sha256_sha224_hash_engine_core #(
    parameter int LENGTH_BITS = sha2_pkg::LenBitsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sha2_pkg::sha2_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sha2_pkg::sha2_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import sha2_pkg::*;
`include "assert_macros.svh"

    logic [7:0]  buf_mem [64];
    logic [31:0] cv_mem  [8];

    sha2_state_t st_reg, st_next;
    logic [5:0]  fill_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic        mode_reg;
    logic        last_reg;      // message finishing
    logic        two_reg;       // padding needs an extra block
    logic        lenph_reg;     // writing the length field
    logic [6:0]  cnt_reg;
    logic [7:0]  brd_reg;
    logic [31:0] crd_reg;
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [23:0] wacc_reg;
    sha2_out_t   out_reg;
    logic        ov_reg;

    logic [63:0] bits_len;
    assign bits_len = {61'(len_reg), 3'b000};

    logic in_acc;
    assign in_stall  = (st_reg != ST_IDLE) || cfg_valid;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (st_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // byte buffer write port
    logic       bw_en;
    logic [5:0] bw_addr;
    logic [7:0] bw_data;
    logic [5:0] br_addr;
    always_comb
    begin
        bw_en = 1'b0;
        bw_addr = fill_reg;
        bw_data = in_data.data_byte;
        if (st_reg == ST_IDLE && in_acc && in_data.has_byte)
            bw_en = 1'b1;
        else if (st_reg == ST_PAD)
        begin
            bw_en = 1'b1;
            if (lenph_reg)
                bw_data = bits_len[8*(7-(fill_reg[2:0]))+:8];
            else if (!last_reg)
                bw_data = PadByte;
            else
                bw_data = 8'h00;
        end
        br_addr = cnt_reg[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (bw_en)
            buf_mem[bw_addr] <= bw_data;
        brd_reg <= buf_mem[br_addr];
    end

    // chain memory
    logic        cw_en;
    logic [2:0]  cw_addr;
    logic [31:0] cw_data;
    logic [2:0]  cr_addr;
    logic [2:0]  fold_idx;
    logic [31:0] sel_word;
    always_comb
    begin
        fold_idx = 3'(cnt_reg - 7'd1);
        case (fold_idx)
            3'd0: sel_word = a_reg;
            3'd1: sel_word = b_reg;
            3'd2: sel_word = c_reg;
            3'd3: sel_word = d_reg;
            3'd4: sel_word = e_reg;
            3'd5: sel_word = f_reg;
            3'd6: sel_word = g_reg;
            default: sel_word = h_reg;
        endcase
        cw_en = 1'b0;
        cw_addr = cnt_reg[2:0];
        cw_data = init_value(mode_reg, cnt_reg[2:0]);
        cr_addr = cnt_reg[2:0];
        if (st_reg == ST_INIT)
            cw_en = 1'b1;
        else if (st_reg == ST_FOLD && cnt_reg != 7'd0)
        begin
            cw_en = 1'b1;
            cw_addr = fold_idx;
            cw_data = crd_reg + sel_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
            cv_mem[cw_addr] <= cw_data;
        crd_reg <= cv_mem[cr_addr];
    end

    // round logic
    logic [31:0] t1, t2, s0w, s1w, wnew, wcur;
    always_comb
    begin
        s0w = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
              ^ (w_reg[1] >> 3);
        s1w = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
              ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0w + w_reg[9] + s1w;
        wcur = w_reg[0];
        t1 = h_reg + ({e_reg[5:0], e_reg[31:6]} ^ {e_reg[10:0], e_reg[31:11]}
             ^ {e_reg[24:0], e_reg[31:25]}) + ((e_reg & f_reg) ^ (~e_reg & g_reg))
             + round_k(cnt_reg[5:0]) + wcur;
        t2 = ({a_reg[1:0], a_reg[31:2]} ^ {a_reg[12:0], a_reg[31:13]}
             ^ {a_reg[21:0], a_reg[31:22]})
             + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
    end

    // next state
    logic done_pad;
    assign done_pad = lenph_reg && (fill_reg == 6'd63);
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_INIT:  if (cnt_reg[2:0] == 3'd7) st_next = ST_IDLE;
            ST_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                    st_next = ST_INIT;
                else if (in_acc)
                begin
                    if (in_data.has_byte && fill_reg == 6'd63)
                        st_next = ST_LOADW;
                    else if (in_data.is_last)
                        st_next = ST_PAD;
                end
            end
            ST_PAD:
                if (done_pad || (fill_reg == 6'd63)) st_next = ST_LOADW;
            ST_LOADW: if (cnt_reg == 7'd64) st_next = ST_ROUND;
            ST_ROUND: if (cnt_reg[5:0] == 6'd63) st_next = ST_FOLD;
            ST_FOLD:
                if (cnt_reg == 7'd8)
                begin
                    if (two_reg) st_next = ST_PAD;
                    else if (last_reg) st_next = ST_OUTRD;
                    else st_next = ST_IDLE;
                end
            ST_OUTRD: st_next = ST_OUT;
            ST_OUT:
                if (!ov_reg || !out_stall)
                begin
                    if (cnt_reg[2:0] == (mode_reg ? 3'd6 : 3'd7)) st_next = ST_INIT;
                    else st_next = ST_OUTRD;
                end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_INIT;
            fill_reg <= '0;
            len_reg <= '0;
            mode_reg <= 1'b0;
            last_reg <= 1'b0;
            two_reg <= 1'b0;
            lenph_reg <= 1'b0;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            case (st_reg)
                ST_INIT:
                begin
                    cnt_reg <= (cnt_reg[2:0] == 3'd7) ? 7'd0 : cnt_reg + 7'd1;
                    fill_reg <= '0;
                    len_reg <= '0;
                    last_reg <= 1'b0;
                    two_reg <= 1'b0;
                    lenph_reg <= 1'b0;
                end
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (cfg_valid && cfg_ready)
                        mode_reg <= cfg_data;
                    else if (in_acc)
                    begin
                        if (in_data.has_byte)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            len_reg <= len_reg + 1'b1;
                        end
                        if (in_data.is_last)
                        begin
                            last_reg <= 1'b0;
                            two_reg <= 1'b1;
                        end
                    end
                end
                ST_PAD:
                begin
                    // last_reg low: writing 0x80; then zeros, then length
                    fill_reg <= fill_reg + 6'd1;
                    if (!last_reg)
                    begin
                        last_reg <= 1'b1;
                        two_reg <= (fill_reg >= LenPos);
                    end
                    if (fill_reg == 6'd63)
                        lenph_reg <= 1'b0;
                    else if ((fill_reg + 6'd1 == LenPos) && (!last_reg || !two_reg))
                        lenph_reg <= 1'b1;
                end
                ST_LOADW:
                    cnt_reg <= (cnt_reg == 7'd64) ? 7'd0 : cnt_reg + 7'd1;
                ST_ROUND:
                    cnt_reg <= (cnt_reg[5:0] == 6'd63) ? 7'd0 : cnt_reg + 7'd1;
                ST_FOLD:
                begin
                    cnt_reg <= (cnt_reg == 7'd8) ? 7'd0 : cnt_reg + 7'd1;
                    if (cnt_reg == 7'd8)
                        two_reg <= 1'b0;
                end
                ST_OUTRD: ;
                ST_OUT:
                    if (!ov_reg || !out_stall)
                    begin
                        cnt_reg <= (cnt_reg[2:0] == (mode_reg ? 3'd6 : 3'd7)) ? 7'd0
                                   : cnt_reg + 7'd1;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_LOADW && cnt_reg != 7'd0)
        begin
            wacc_reg <= {wacc_reg[15:0], brd_reg};
            if (cnt_reg[1:0] == 2'd0)
            begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= {wacc_reg, brd_reg};
            end
        end
        // chain value into the working registers, word 0 ends in a_reg
        if (st_reg == ST_LOADW && cnt_reg != 7'd0 && cnt_reg <= 7'd8)
        begin
            h_reg <= crd_reg; g_reg <= h_reg; f_reg <= g_reg; e_reg <= f_reg;
            d_reg <= e_reg; c_reg <= d_reg; b_reg <= c_reg; a_reg <= b_reg;
        end
        if (st_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
        if (st_reg == ST_OUT && (!ov_reg || !out_stall))
        begin
            out_reg.digest_word <= crd_reg;
            out_reg.word_last <= (cnt_reg[2:0] == (mode_reg ? 3'd6 : 3'd7));
        end
    end

    `ASSERT_CLK(a_no_in_busy, clk, rst_n, (st_reg != ST_IDLE) |-> !in_acc,
        "item accepted while busy")
    `ASSERT_CLK(a_cfg_idle, clk, rst_n, (cfg_valid && cfg_ready) |-> !ov_reg,
        "config while output pending")
    `ASSERT_CLK(a_init_next, clk, rst_n, (st_reg == ST_OUT && !ov_reg) |=> ov_reg,
        "digest word dropped")

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha2_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int LenBits = 61;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    sha2_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    sha2_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    sha256_sha224_hash_engine_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // hash state of the model
    logic        sel224;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [LenBits-1:0] msg_len;

    sha2_out_t digest_q[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  rand_stall = 1'b1;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] Iv256 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] Iv224 [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            chain[i] = sel224 ? Iv224[i] : Iv256[i];
        fill = 0;
        msg_len = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                    chain[4], chain[5], chain[6], chain[7]};
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                + RoundK[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic hash_item(input sha2_in_t it);
        logic [63:0] bits;
        int nw;
        sha2_out_t r;
        if (it.has_byte)
        begin
            blk[fill] = it.data_byte;
            fill = (fill + 1) % 64;
            msg_len = msg_len + 1'b1;
            if (fill == 0)
                compress_block();
        end
        if (!it.is_last)
            return;
        bits = {3'b0, msg_len} << 3;
        blk[fill] = 8'h80;
        fill++;
        if (fill > 56)
        begin
            while (fill < 64)
                blk[fill++] = 8'h00;
            compress_block();
            fill = 0;
        end
        while (fill < 56)
            blk[fill++] = 8'h00;
        for (int i = 0; i < 8; i++)
            blk[63-i] = bits[8*i +: 8];
        compress_block();
        nw = sel224 ? 7 : 8;
        for (int i = 0; i < nw; i++)
        begin
            r.digest_word = chain[i];
            r.word_last = (i + 1 == nw);
            digest_q.push_back(r);
        end
        restart_hash();
    endtask

    // output side
    always @(posedge clk)
    begin
        sha2_out_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", out_data.digest_word);
                errors++;
            end
            else
            begin
                exp_w = digest_q.pop_front();
                if (out_data.digest_word !== exp_w.digest_word)
                begin
                    $error("digest_word expected %h actual %h",
                           exp_w.digest_word, out_data.digest_word);
                    errors++;
                end
                if (out_data.word_last !== exp_w.word_last)
                begin
                    $error("word_last expected %b actual %b",
                           exp_w.word_last, out_data.word_last);
                    errors++;
                end
            end
        end
    end

    // wait drawn when a word is about to be taken, applied to the next word
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (!rand_stall)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            stall_left = $urandom_range(0, 9);
            out_stall <= 1'b0;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("sha256_sha224_hash_engine_core: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic hb, input logic last,
                             input bit gaps = 1'b1);
        sha2_in_t it;
        int gap;
        it.data_byte = b;
        it.has_byte = hb;
        it.is_last = last;
        gap = gaps ? $urandom_range(0, 9) : 0;
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        in_data = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hash_item(it);
        @(negedge clk);
        in_valid = 1'b0;
        in_data = sha2_in_t'(10'($urandom));
    endtask

    task automatic drain();
        while (digest_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sel224 = m;
        restart_hash();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message(input int len, input bit gaps = 1'b1);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, gaps);
        if ($urandom_range(0, 1))
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, gaps);
        else
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, gaps);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);                // empty message
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);                // no effect
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'ha5, 1'b1, 1'b1);
        drain();                                     // sender waits for all results
    endtask

    task automatic test_sha224();
        write_mode(1'b1);
        send_item(8'h61, 1'b1, 1'b1);
        send_message(55);                            // padding spills to extra block if last item has a byte
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_block_edges();
        write_mode(1'b0);
        rand_stall = 1'b0;
        for (int i = 0; i < 63; i++)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);  // last byte fills block
        rand_stall = 1'b1;
        // partial message dropped by a mode write
        for (int i = 0; i < 3; i++)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        write_mode(1'b1);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random();
        int n;
        for (int m = 0; m < 4; m++)
        begin
            if (m % 2 == 0)
                write_mode(1'($urandom_range(0, 1)));
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    initial
    begin
        sel224 = 1'b0;
        restart_hash();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_sha224();
        test_block_edges();
        test_random();
        drain();
        if (errors == 0 && digest_q.size() == 0)
            $display("sha256_sha224_hash_engine_core: match");
        else
            $display("sha256_sha224_hash_engine_core: mismatch");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/sha2_pkg.sv
sv/sha256_sha224_hash_engine_core.sv
verif/testbench.sv
